FILE: rtl/core/prs_pkg.sv
// Shared constants, datapath opcodes and status word for the primitive root search.
`default_nettype none
package prs_pkg;

  // Default modulus width and fixed result width
  localparam int MOD_WIDTH_DEF = 16;
  localparam int ROOT_WIDTH    = 16;

  // Exponent table: one entry per distinct prime factor of n-1
  localparam int MAX_FACTORS = 16;
  localparam int FAC_IDX_W   = $clog2(MAX_FACTORS);
  localparam int FAC_CNT_W   = FAC_IDX_W + 1;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,        // capture modulus
    OP_TRIAL_INIT,  // d = 2, d*d = 4 for the primality test
    OP_FACT_INIT,   // v = n-1, d = 2, table empty
    OP_D_NEXT,      // d = d+1, square updated incrementally
    OP_DIV_N_D,     // divider: n / d
    OP_DIV_V_D,     // divider: v / d
    OP_DIV_NM1_D,   // divider: (n-1) / d
    OP_DIV_NM1_V,   // divider: (n-1) / v
    OP_V_SHRINK,    // v = quotient
    OP_STORE_EXP,   // table[cnt] = quotient
    OP_G_INIT,      // g = 2, k = 0
    OP_POW_INIT,    // acc = 1, b = g, e = table[k]
    OP_MUL_ACC_B,   // mulmod: acc * b
    OP_MUL_B_B,     // mulmod: b * b
    OP_ACC_LOAD,    // acc = product
    OP_B_LOAD,      // b = product, e >>= 1
    OP_G_NEXT,      // g = g+1, k = 0
    OP_K_NEXT,      // k = k+1
    OP_RES_FOUND,   // result word = {g, 1}
    OP_RES_NONE     // result word = {0, 0}
  } dp_op_t;

  // Status flags from datapath to controller
  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic mul_done;
    logic small_mod;
    logic sq_gt_n;
    logic sq_gt_v;
    logic v_gt_one;
    logic e_zero;
    logic e_lsb;
    logic acc_one;
    logic g_at_n;
    logic k_end;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/prs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module prs_div #(
  parameter int MOD_WIDTH = prs_pkg::MOD_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [MOD_WIDTH-1:0] dividend,
  input  wire logic [MOD_WIDTH-1:0] divisor,
  output logic      [MOD_WIDTH-1:0] quot,
  output logic      [MOD_WIDTH-1:0] rem,
  output logic                      done
);
  localparam int CW = $clog2(MOD_WIDTH);

  logic [MOD_WIDTH-1:0] rem_r, quo_r, div_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;

  logic [MOD_WIDTH:0]   rem_sh;
  logic [MOD_WIDTH+1:0] diff;
  logic                 ge;

  // Shift in next dividend bit, trial subtract
  assign rem_sh = {rem_r, quo_r[MOD_WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_r};
  assign ge     = ~diff[MOD_WIDTH+1];

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      div_r  <= divisor;
      cnt_r  <= CW'(MOD_WIDTH - 1);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rem_r <= ge ? diff[MOD_WIDTH-1:0] : rem_sh[MOD_WIDTH-1:0];
      quo_r <= {quo_r[MOD_WIDTH-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end
  end

  assign quot = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule
`default_nettype wire

FILE: rtl/core/prs_mulmod.sv
// Interleaved modular multiplier: (a*b) mod m, one multiplier bit per cycle, MSB first.
`default_nettype none
module prs_mulmod #(
  parameter int MOD_WIDTH = prs_pkg::MOD_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [MOD_WIDTH-1:0] a,
  input  wire logic [MOD_WIDTH-1:0] b,
  input  wire logic [MOD_WIDTH-1:0] m,
  output logic      [MOD_WIDTH-1:0] prod,
  output logic                      done
);
  localparam int CW = $clog2(MOD_WIDTH);

  logic [MOD_WIDTH-1:0] acc_r, a_r, b_r, m_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;

  logic [MOD_WIDTH+1:0] t, m1, m2, t_m1, t_m2;
  logic [MOD_WIDTH-1:0] acc_nxt;

  // 2*acc + bit*a stays below 3m; reduce by m or 2m
  assign t    = {1'b0, acc_r, 1'b0} + {2'b00, (b_r[MOD_WIDTH-1] ? a_r : '0)};
  assign m1   = {2'b00, m_r};
  assign m2   = {1'b0, m_r, 1'b0};
  assign t_m1 = t - m1;
  assign t_m2 = t - m2;

  always_comb begin
    if (t >= m2) begin
      acc_nxt = t_m2[MOD_WIDTH-1:0];
    end else if (t >= m1) begin
      acc_nxt = t_m1[MOD_WIDTH-1:0];
    end else begin
      acc_nxt = t[MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (start) begin
      acc_r  <= '0;
      a_r    <= a;
      b_r    <= b;
      m_r    <= m;
      cnt_r  <= CW'(MOD_WIDTH - 1);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[MOD_WIDTH-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule
`default_nettype wire

FILE: rtl/core/prs_datapath.sv
// Datapath: modulus, trial divisor, exponent table, power registers and the result word.
`default_nettype none
module prs_datapath #(
  parameter int MOD_WIDTH = prs_pkg::MOD_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire prs_pkg::dp_op_t                 op,
  output prs_pkg::dp_stat_t                    stat,
  input  wire logic [MOD_WIDTH-1:0]            in_modulus,
  output logic      [prs_pkg::ROOT_WIDTH-1:0]  out_root,
  output logic                                 out_found
);
  localparam int SQW = MOD_WIDTH + 2;
  localparam int IW  = prs_pkg::FAC_IDX_W;
  localparam int KW  = prs_pkg::FAC_CNT_W;

  logic [MOD_WIDTH-1:0] n_r, v_r, d_r, g_r, acc_r, b_r, e_r;
  logic [SQW-1:0]       sq_r;
  logic [KW-1:0]        k_r, cnt_r;
  logic [MOD_WIDTH-1:0] exp_r [prs_pkg::MAX_FACTORS];
  logic [prs_pkg::ROOT_WIDTH-1:0] root_r;
  logic                 found_r;

  logic [MOD_WIDTH-1:0] n_m1;
  logic [MOD_WIDTH+prs_pkg::ROOT_WIDTH-1:0] g_ext;

  // Divider and multiplier operand selection
  logic                 div_start, mul_start;
  logic [MOD_WIDTH-1:0] div_a, div_b, quot, rem, mul_a, prod;
  logic                 div_done, mul_done;

  assign n_m1  = n_r - 1'b1;
  assign g_ext = {{prs_pkg::ROOT_WIDTH{1'b0}}, g_r};

  always_comb begin
    div_start = 1'b0;
    div_a     = n_r;
    div_b     = d_r;
    mul_start = 1'b0;
    mul_a     = b_r;
    case (op)
      prs_pkg::OP_DIV_N_D: begin
        div_start = 1'b1;
      end
      prs_pkg::OP_DIV_V_D: begin
        div_start = 1'b1;
        div_a     = v_r;
      end
      prs_pkg::OP_DIV_NM1_D: begin
        div_start = 1'b1;
        div_a     = n_m1;
      end
      prs_pkg::OP_DIV_NM1_V: begin
        div_start = 1'b1;
        div_a     = n_m1;
        div_b     = v_r;
      end
      prs_pkg::OP_MUL_ACC_B: begin
        mul_start = 1'b1;
        mul_a     = acc_r;
      end
      prs_pkg::OP_MUL_B_B: begin
        mul_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  prs_div #(.MOD_WIDTH(MOD_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  prs_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (b_r),
    .m     (n_r),
    .prod  (prod),
    .done  (mul_done)
  );

  // Register updates per operation
  always_ff @(posedge clk) begin
    case (op)
      prs_pkg::OP_LOAD: begin
        n_r <= in_modulus;
      end
      prs_pkg::OP_TRIAL_INIT: begin
        d_r  <= MOD_WIDTH'(2);
        sq_r <= SQW'(4);
      end
      prs_pkg::OP_FACT_INIT: begin
        v_r   <= n_m1;
        d_r   <= MOD_WIDTH'(2);
        sq_r  <= SQW'(4);
        cnt_r <= '0;
      end
      prs_pkg::OP_D_NEXT: begin
        d_r  <= d_r + 1'b1;
        sq_r <= sq_r + {1'b0, d_r, 1'b1};
      end
      prs_pkg::OP_V_SHRINK: begin
        v_r <= quot;
      end
      prs_pkg::OP_STORE_EXP: begin
        if (cnt_r < KW'(prs_pkg::MAX_FACTORS)) begin
          exp_r[cnt_r[IW-1:0]] <= quot;
          cnt_r                <= cnt_r + 1'b1;
        end
      end
      prs_pkg::OP_G_INIT: begin
        g_r <= MOD_WIDTH'(2);
        k_r <= '0;
      end
      prs_pkg::OP_POW_INIT: begin
        acc_r <= MOD_WIDTH'(1);
        b_r   <= g_r;
        e_r   <= exp_r[k_r[IW-1:0]];
      end
      prs_pkg::OP_ACC_LOAD: begin
        acc_r <= prod;
      end
      prs_pkg::OP_B_LOAD: begin
        b_r <= prod;
        e_r <= {1'b0, e_r[MOD_WIDTH-1:1]};
      end
      prs_pkg::OP_G_NEXT: begin
        g_r <= g_r + 1'b1;
        k_r <= '0;
      end
      prs_pkg::OP_K_NEXT: begin
        k_r <= k_r + 1'b1;
      end
      prs_pkg::OP_RES_FOUND: begin
        root_r  <= g_ext[prs_pkg::ROOT_WIDTH-1:0];
        found_r <= 1'b1;
      end
      prs_pkg::OP_RES_NONE: begin
        root_r  <= '0;
        found_r <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Status back to the controller
  assign stat.div_done  = div_done;
  assign stat.rem_zero  = (rem == '0);
  assign stat.mul_done  = mul_done;
  assign stat.small_mod = (n_r < MOD_WIDTH'(3));
  assign stat.sq_gt_n   = (sq_r > {2'b00, n_r});
  assign stat.sq_gt_v   = (sq_r > {2'b00, v_r});
  assign stat.v_gt_one  = (v_r > MOD_WIDTH'(1));
  assign stat.e_zero    = (e_r == '0);
  assign stat.e_lsb     = e_r[0];
  assign stat.acc_one   = (acc_r == MOD_WIDTH'(1));
  assign stat.g_at_n    = (g_r == n_r);
  assign stat.k_end     = (k_r == cnt_r);

  assign out_root  = root_r;
  assign out_found = found_r;

endmodule
`default_nettype wire

FILE: rtl/core/prs_ctrl.sv
// Controller: sequences primality test, factoring of n-1 and the candidate order tests.
`default_nettype none
module prs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output prs_pkg::dp_op_t        op,
  input  wire prs_pkg::dp_stat_t stat
);
  typedef enum logic [4:0] {
    S_IDLE,
    S_SMALL,
    S_PR_TEST,
    S_PR_WAIT,
    S_FA_TEST,
    S_FA_WAIT,
    S_FA_EXP,
    S_FA_STRIP,
    S_FA_SWAIT,
    S_FA_LAST,
    S_FA_LWAIT,
    S_G_INIT,
    S_PW_INIT,
    S_PW_CHECK,
    S_PW_MACC,
    S_PW_SQ,
    S_PW_MSQ,
    S_PW_EVAL,
    S_PW_GCHK,
    S_FIN_FOUND,
    S_FIN_NONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result slot can take a new word
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt     = state_r;
    op            = prs_pkg::OP_NONE;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = prs_pkg::OP_LOAD;
          state_nxt = S_SMALL;
        end
      end
      S_SMALL: begin
        if (stat.small_mod) begin
          state_nxt = S_FIN_NONE;
        end else begin
          op        = prs_pkg::OP_TRIAL_INIT;
          state_nxt = S_PR_TEST;
        end
      end
      // trial division of n
      S_PR_TEST: begin
        if (stat.sq_gt_n) begin
          op        = prs_pkg::OP_FACT_INIT;
          state_nxt = S_FA_TEST;
        end else begin
          op        = prs_pkg::OP_DIV_N_D;
          state_nxt = S_PR_WAIT;
        end
      end
      S_PR_WAIT: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            state_nxt = S_FIN_NONE;
          end else begin
            op        = prs_pkg::OP_D_NEXT;
            state_nxt = S_PR_TEST;
          end
        end
      end
      // distinct prime factors of n-1, storing (n-1)/q
      S_FA_TEST: begin
        if (stat.sq_gt_v) begin
          state_nxt = S_FA_LAST;
        end else begin
          op        = prs_pkg::OP_DIV_V_D;
          state_nxt = S_FA_WAIT;
        end
      end
      S_FA_WAIT: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            op        = prs_pkg::OP_DIV_NM1_D;
            state_nxt = S_FA_EXP;
          end else begin
            op        = prs_pkg::OP_D_NEXT;
            state_nxt = S_FA_TEST;
          end
        end
      end
      S_FA_EXP: begin
        if (stat.div_done) begin
          op        = prs_pkg::OP_STORE_EXP;
          state_nxt = S_FA_STRIP;
        end
      end
      S_FA_STRIP: begin
        op        = prs_pkg::OP_DIV_V_D;
        state_nxt = S_FA_SWAIT;
      end
      S_FA_SWAIT: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            op        = prs_pkg::OP_V_SHRINK;
            state_nxt = S_FA_STRIP;
          end else begin
            op        = prs_pkg::OP_D_NEXT;
            state_nxt = S_FA_TEST;
          end
        end
      end
      S_FA_LAST: begin
        if (stat.v_gt_one) begin
          op        = prs_pkg::OP_DIV_NM1_V;
          state_nxt = S_FA_LWAIT;
        end else begin
          op        = prs_pkg::OP_G_INIT;
          state_nxt = S_PW_INIT;
        end
      end
      S_FA_LWAIT: begin
        if (stat.div_done) begin
          op        = prs_pkg::OP_STORE_EXP;
          state_nxt = S_G_INIT;
        end
      end
      S_G_INIT: begin
        op        = prs_pkg::OP_G_INIT;
        state_nxt = S_PW_INIT;
      end
      // g^e mod n by square and multiply, LSB first
      S_PW_INIT: begin
        if (stat.k_end) begin
          state_nxt = S_FIN_FOUND;
        end else begin
          op        = prs_pkg::OP_POW_INIT;
          state_nxt = S_PW_CHECK;
        end
      end
      S_PW_CHECK: begin
        if (stat.e_zero) begin
          state_nxt = S_PW_EVAL;
        end else if (stat.e_lsb) begin
          op        = prs_pkg::OP_MUL_ACC_B;
          state_nxt = S_PW_MACC;
        end else begin
          op        = prs_pkg::OP_MUL_B_B;
          state_nxt = S_PW_MSQ;
        end
      end
      S_PW_MACC: begin
        if (stat.mul_done) begin
          op        = prs_pkg::OP_ACC_LOAD;
          state_nxt = S_PW_SQ;
        end
      end
      S_PW_SQ: begin
        op        = prs_pkg::OP_MUL_B_B;
        state_nxt = S_PW_MSQ;
      end
      S_PW_MSQ: begin
        if (stat.mul_done) begin
          op        = prs_pkg::OP_B_LOAD;
          state_nxt = S_PW_CHECK;
        end
      end
      // power of 1 rejects the candidate
      S_PW_EVAL: begin
        if (stat.acc_one) begin
          op        = prs_pkg::OP_G_NEXT;
          state_nxt = S_PW_GCHK;
        end else begin
          op        = prs_pkg::OP_K_NEXT;
          state_nxt = S_PW_INIT;
        end
      end
      S_PW_GCHK: begin
        state_nxt = stat.g_at_n ? S_FIN_NONE : S_PW_INIT;
      end
      S_FIN_FOUND: begin
        if (out_free) begin
          op            = prs_pkg::OP_RES_FOUND;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FIN_NONE: begin
        if (out_free) begin
          op            = prs_pkg::OP_RES_NONE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: rtl/core/primitive_root_search.sv
// Top level of the smallest primitive root search.
// Each input word is a modulus n; the block returns one result word: the smallest g in
// 2..n-1 whose multiplicative order mod n is n-1, with found=1, or root=0 and found=0
// when n is below 3 or composite. One modulus is worked at a time; in_stall stays high
// from acceptance until the result is written into the output register, and the next
// modulus may be taken while that result still waits on out_stall. Run time depends on
// n: trial division costs about sqrt(n) divisions, factoring n-1 about sqrt(n) more,
// each in the one-bit-per-cycle divider; each candidate g then needs, per distinct
// prime factor of n-1, up to 2*MOD_WIDTH modular products in the serial multiplier.
// Moduli below 3 and even moduli finish far sooner than large primes.
`default_nettype none
module primitive_root_search #(
  parameter int MOD_WIDTH = prs_pkg::MOD_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [MOD_WIDTH-1:0]           in_modulus,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [prs_pkg::ROOT_WIDTH-1:0]      out_root,
  output logic                                out_found
);
  prs_pkg::dp_op_t   op;
  prs_pkg::dp_stat_t stat;

  prs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op),
    .stat      (stat)
  );

  prs_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .in_modulus (in_modulus),
    .out_root   (out_root),
    .out_found  (out_found)
  );

endmodule
`default_nettype wire

FILE: rtl/core/prs_checker.sv
// Port-level checks for the primitive root search, bound to the top level.
`default_nettype none
module prs_checker #(
  parameter int MOD_WIDTH = prs_pkg::MOD_WIDTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [MOD_WIDTH-1:0]          in_modulus,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [prs_pkg::ROOT_WIDTH-1:0] out_root,
  input wire logic                          out_found
);

  // A stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_modulus))
    else $error("input word changed while stalled");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_root) && $stable(out_found))
    else $error("result word changed while stalled");

  // No root reported means a zero root
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_root == '0)
    else $error("nonzero root without found");

  // A reported root is never below two
  a_root_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_root >= prs_pkg::ROOT_WIDTH'(2))
    else $error("root below two");

  // One modulus at a time: input closes right after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accepting a word");

endmodule

bind primitive_root_search prs_checker #(.MOD_WIDTH(MOD_WIDTH)) u_prs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_modulus (in_modulus),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_root   (out_root),
  .out_found  (out_found)
);
`default_nettype wire

FILE: test/primitive_root_search_tb.sv
// Self-checking testbench for the smallest primitive root search block.
`default_nettype none
module primitive_root_search_tb;

  localparam int LIMIT     = 4_000_000;  // cycle budget for the whole run
  localparam int LONG_HOLD = 2000;       // receiver hold-off, in cycles
  localparam int TAIL      = 100;        // quiet cycles after the last result
  localparam int N_DIR     = 22;

  // One stimulus word; known rows carry their expected result
  typedef struct packed {
    logic [15:0] modulus;
    logic        known;
    logic [15:0] root;
    logic        found;
  } mod_word_t;

  typedef struct packed {
    logic [15:0] root;
    logic        found;
  } root_res_t;

  // Directed rows: tiny moduli, extremes, composites and a few primes
  localparam mod_word_t DIR_ROWS [0:N_DIR-1] = '{
    '{16'd0,     1'b1, 16'd0, 1'b0},
    '{16'd1,     1'b1, 16'd0, 1'b0},
    '{16'd2,     1'b1, 16'd0, 1'b0},
    '{16'd3,     1'b1, 16'd2, 1'b1},
    '{16'd4,     1'b1, 16'd0, 1'b0},
    '{16'd5,     1'b1, 16'd2, 1'b1},
    '{16'd6,     1'b1, 16'd0, 1'b0},
    '{16'd7,     1'b1, 16'd3, 1'b1},
    '{16'd9,     1'b1, 16'd0, 1'b0},
    '{16'd65535, 1'b1, 16'd0, 1'b0},
    '{16'd32768, 1'b1, 16'd0, 1'b0},
    '{16'd65534, 1'b1, 16'd0, 1'b0},
    '{16'd11,    1'b0, 16'd0, 1'b0},
    '{16'd13,    1'b0, 16'd0, 1'b0},
    '{16'd25,    1'b0, 16'd0, 1'b0},
    '{16'd41,    1'b0, 16'd0, 1'b0},
    '{16'd191,   1'b0, 16'd0, 1'b0},
    '{16'd257,   1'b0, 16'd0, 1'b0},
    '{16'd409,   1'b0, 16'd0, 1'b0},
    '{16'd4097,  1'b0, 16'd0, 1'b0},
    '{16'd65521, 1'b0, 16'd0, 1'b0},
    '{16'd32749, 1'b0, 16'd0, 1'b0}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [15:0]           in_modulus = '0;
  logic                  out_stall = 1'b0;
  wire                   in_stall;
  wire                   out_valid;
  wire [prs_pkg::ROOT_WIDTH-1:0] out_root;
  wire                   out_found;

  primitive_root_search #(.MOD_WIDTH(16)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_modulus(in_modulus),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_root  (out_root),
    .out_found (out_found)
  );

  mod_word_t pend_q [$];   // words waiting to be offered
  root_res_t root_q [$];   // roots expected, oldest first
  mod_word_t cur_word;
  root_res_t want;

  int idle_pct    = 0;
  int stall_pct   = 0;
  bit hold_start  = 1'b0;
  bit recv_hold   = 1'b0;
  bit hold_done   = 1'b0;
  int err_cnt     = 0;
  int sent_cnt    = 0;
  int got_cnt     = 0;
  int prime_cnt   = 0;
  int cycle_cnt   = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Modular power by square and multiply; operands stay below 2^16
  function automatic longint unsigned power_mod(longint unsigned base, longint unsigned ex,
                                                longint unsigned m);
    longint unsigned acc;
    longint unsigned b;
    acc = 1 % m;
    b   = base % m;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * b) % m;
      b  = (b * b) % m;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic bit prime_test(longint unsigned n);
    longint unsigned d;
    bit p;
    p = (n >= 2);
    d = 2;
    while (p && d * d <= n) begin
      if (n % d == 0) p = 1'b0;
      d++;
    end
    return p;
  endfunction

  // Smallest g in 2..n-1 with g^((n-1)/q) != 1 for each prime q dividing n-1
  function automatic root_res_t expected_root(logic [15:0] m);
    longint unsigned n, v, d, g;
    longint unsigned fac [0:15];
    int cnt;
    bit ok;
    root_res_t r;
    r = '0;
    n = m;
    if (n >= 3 && prime_test(n)) begin
      cnt = 0;
      v = n - 1;
      d = 2;
      while (d * d <= v) begin
        if (v % d == 0) begin
          if (cnt < 16) begin
            fac[cnt] = d;
            cnt++;
          end
          while (v % d == 0) v = v / d;
        end
        d++;
      end
      if (v > 1 && cnt < 16) begin
        fac[cnt] = v;
        cnt++;
      end
      g = 2;
      while (!r.found && g < n) begin
        ok = 1'b1;
        for (int k = 0; k < cnt; k++)
          if (ok && power_mod(g, (n - 1) / fac[k], n) == 1) ok = 1'b0;
        if (ok) begin
          r.root  = g[15:0];
          r.found = 1'b1;
        end
        g++;
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] next_prime(int unsigned start);
    int unsigned n;
    n = start;
    while (!prime_test(n)) n++;
    return n[15:0];
  endfunction

  // Small primes, which walk the whole search, are the largest share; some noise and a few large ones
  function automatic logic [15:0] rand_modulus();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return next_prime($urandom_range(3, 1000));
    else if (pick < 70) return 16'($urandom_range(1023));
    else if (pick < 82) return 16'($urandom_range(16));
    else if (pick < 97) return 16'($urandom_range(65535));
    else return next_prime($urandom_range(30000, 65500));
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    err_cnt++;
  endtask

  task automatic queue_random(int count);
    mod_word_t w;
    for (int i = 0; i < count; i++) begin
      w = '0;
      w.modulus = rand_modulus();
      pend_q.insert(pend_q.size(), w);
    end
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || in_valid || root_q.size() != 0) @(negedge clk);
  endtask

  // Sender: holds a stalled word, otherwise offers the next one or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_word.known) root_q.insert(root_q.size(), {cur_word.root, cur_word.found});
        else root_q.insert(root_q.size(), expected_root(cur_word.modulus));
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_word   = pend_q.pop_front();
          in_valid   <= 1'b1;
          in_modulus <= cur_word.modulus;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, or forced high during the long hold-off
  always @(posedge clk) begin
    if (recv_hold) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off, timed here
  initial begin : recv_hold_timer
    wait (hold_start);
    @(negedge clk);
    recv_hold = 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    recv_hold = 1'b0;
    hold_done = 1'b1;
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_cnt++;
      if (root_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word root=%0d found=%0d", out_root, out_found));
      end else begin
        want = root_q.pop_front();
        if (out_found) prime_cnt++;
        if (out_root !== want.root)
          flag_mismatch($sformatf("root %0d, expected %0d", out_root, want.root));
        if (out_found !== want.found)
          flag_mismatch($sformatf("found %0d, expected %0d", out_found, want.found));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, root_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main
    mod_word_t w;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed table, no idling
    for (int i = 0; i < N_DIR; i++) pend_q.insert(pend_q.size(), DIR_ROWS[i]);
    wait_drained();

    // Sender mostly idle
    idle_pct = 85;
    queue_random(20);
    wait_drained();

    // Receiver mostly stalling
    idle_pct  = 0;
    stall_pct = 85;
    queue_random(20);
    wait_drained();

    // Light idling on both sides
    idle_pct  = 10;
    stall_pct = 10;
    queue_random(20);
    wait_drained();

    // Long receiver hold-off while small moduli keep coming
    idle_pct   = 0;
    stall_pct  = 0;
    hold_start = 1'b1;
    for (int i = 0; i < 8; i++) begin
      w = '0;
      w.modulus = 16'($urandom_range(3, 63));
      pend_q.insert(pend_q.size(), w);
    end
    wait (hold_done);
    wait_drained();

    // Free-running stretch
    queue_random(10);
    wait_drained();

    repeat (TAIL) @(negedge clk);
    $display("Sent %0d moduli (%0d directed) in %0d cycles; %0d results, %0d with a root.",
             sent_cnt, N_DIR, cycle_cnt, got_cnt, prime_cnt);
    $display("Phases: no idling, idle sender, stalling receiver, mixed, long hold-off.");
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
